// ----- hw/rtl/dpsp_pkg.sv -----
package dpsp_pkg;

   // Divider geometry: 16-bit dividend, 9-bit divisor, 8-bit quotient
   localparam int DVD_W = 16;
   localparam int DSR_W = 9;
   localparam int QUO_W = 8;
   localparam int DSH_W = DSR_W + QUO_W - 1;

   // Raw sample and calibration widths
   localparam int RAW_W = 10;
   localparam int VAL_W = 8;
   localparam int DB_W  = 7;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_A    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_B    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_B     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCALE,
      ST_SUM,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic cond;
      logic div_load;
      logic div_step;
      logic sum;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic range_ok;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic             ok;
      logic             zero;
      logic [DVD_W-1:0] dividend;
   } cond_type;

   // Range check, clamp and scale numerator: (clamped - low) * 255
   function automatic cond_type condition(
      input logic [VAL_W-1:0] t,
      input logic [VAL_W-1:0] h,
      input logic [VAL_W-1:0] l,
      input logic [VAL_W-1:0] s
   );
      cond_type         r;
      logic [VAL_W-1:0] tc;
      logic [VAL_W-1:0] d;
      r.ok = 1'b1;
      tc   = t;
      if (t > h) begin
         if ({1'b0, t} > ({1'b0, h} + {1'b0, s})) begin
            r.ok = 1'b0;
         end
         tc = h;
      end
      if (tc < l) begin
         // tc < l - s, evaluated without wrap
         if (({1'b0, tc} + {1'b0, s}) < {1'b0, l}) begin
            r.ok = 1'b0;
         end
         tc = l;
      end
      r.zero     = (h <= l);
      d          = tc - l;
      r.dividend = {d, 8'h00} - {8'h00, d};
      return r;
   endfunction

endpackage

// ----- hw/rtl/dpsp_ram.sv -----
module dpsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dpsp_div.sv -----
// Restoring divider, one quotient bit per step, 8 steps.
// Quotient must fit in QUO_W bits (dividend < 256 * divisor).
module dpsp_div import dpsp_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   logic [DVD_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   // Next remainder, shifted divisor and quotient
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = {divisor, {(QUO_W-1){1'b0}}};
         quo_in = '0;
      end else if (step) begin
         if (DSH_W'(rem_ff) >= dsh_ff) begin
            rem_in = rem_ff - DVD_W'(dsh_ff);
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/dpsp_ctrl.sv -----
module dpsp_ctrl import dpsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       cnt_last;

   assign cnt_last = (cnt_ff == 3'd7);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = status.range_ok ? ST_SCALE : ST_FINISH;
         end
         ST_SCALE: begin
            if (cnt_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Step counter for the scaling divider pass
   always_comb begin
      cnt_in = '0;
      if (state_ff == ST_SCALE) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PREP: begin
            cmd.cond     = 1'b1;
            cmd.div_load = 1'b1;
         end
         ST_SCALE: begin
            cmd.div_step = 1'b1;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/dpsp_datapath.sv -----
module dpsp_datapath import dpsp_pkg::*; #(
   parameter int WINDOW_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [RAW_W-1:0]     req_sensor_a,
   input  logic [RAW_W-1:0]     req_sensor_b,
   input  logic                 req_brake_pressed,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_pedal_a,
   output logic [VAL_W-1:0]     rsp_pedal_b,
   output logic                 rsp_panic,
   output logic                 rsp_disagree_seen,
   output logic [VAL_W-1:0]     rsp_disagree_total,
   output logic                 rsp_brake_lockout,
   output logic                 rsp_brake_active
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = VAL_W + PTR_W;
   localparam logic [VAL_W-1:0] DISAGREE_LIMIT  = 8'd25;
   localparam logic [VAL_W-1:0] LOCKOUT_RELEASE = 8'd38;
   // Window average by reciprocal multiply, exact for every sum below 2**SUM_W
   localparam int RCP_K = SUM_W + PTR_W;
   localparam int PRD_W = 2 * SUM_W + 1;
   localparam logic [SUM_W:0] RCP_M =
      (SUM_W+1)'(((1 << RCP_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

   // Configuration registers
   logic [VAL_W-1:0] high_a_ff, low_a_ff, high_b_ff, low_b_ff, slop_ff;
   logic [DB_W-1:0]  dead_band_ff;

   // Item registers
   logic [VAL_W-1:0] t_a_ff, t_b_ff;
   logic             brake_ff;
   logic             ok_ff, zero_a_ff, zero_b_ff;
   logic [VAL_W-1:0] v_a_ff, v_b_ff;
   logic [SUM_W-1:0] sum_a_new_ff, sum_b_new_ff;

   // Block state
   logic [SUM_W-1:0] sum_a_ff, sum_b_ff;
   logic [PTR_W-1:0] ptr_ff;
   logic             wrapped_ff;
   logic             disagree_ff;
   logic [VAL_W-1:0] dis_cnt_ff;
   logic             lockout_ff;

   // Result register
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_pedal_a_ff, rsp_pedal_b_ff, rsp_total_ff;
   logic             rsp_panic_ff, rsp_seen_ff, rsp_lockout_ff, rsp_brake_ff;

   cond_type         cond_a, cond_b;
   logic [2*VAL_W-1:0] rd_data;
   logic [VAL_W-1:0] old_a, old_b, v_a_sel, v_b_sel;
   logic [SUM_W-1:0] sum_a_new, sum_b_new;
   logic [DVD_W-1:0] dvd_a, dvd_b;
   logic [DSR_W-1:0] dsr_a, dsr_b;
   logic [QUO_W-1:0] q_a, q_b;
   logic [PRD_W-1:0] prod_a, prod_b;
   logic [VAL_W-1:0] avg_a, avg_b;
   logic [VAL_W-1:0] diff, dz_a, dz_b, dz_hi;
   logic             disagree, lk_new, commit, pass;

   function automatic logic [VAL_W-1:0] deadzone(
      input logic [VAL_W-1:0] v,
      input logic [DB_W-1:0]  db,
      input logic [VAL_W-1:0] hi
   );
      logic [VAL_W-1:0] r;
      r = v;
      if (v < {1'b0, db}) begin
         r = '0;
      end else if (v > hi) begin
         r = '1;
      end
      return r;
   endfunction

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_a_ff    <= 8'd231;
         low_a_ff     <= 8'd162;
         high_b_ff    <= 8'd161;
         low_b_ff     <= 8'd109;
         slop_ff      <= 8'd50;
         dead_band_ff <= 7'd10;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HIGH_A:    high_a_ff    <= csr_data;
            CSR_LOW_A:     low_a_ff     <= csr_data;
            CSR_HIGH_B:    high_b_ff    <= csr_data;
            CSR_LOW_B:     low_b_ff     <= csr_data;
            CSR_SLOP:      slop_ff      <= csr_data;
            CSR_DEAD_BAND: dead_band_ff <= csr_data[DB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input capture: keep the top 8 bits of each sample
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_a_ff   <= req_sensor_a[RAW_W-1:RAW_W-VAL_W];
         t_b_ff   <= req_sensor_b[RAW_W-1:RAW_W-VAL_W];
         brake_ff <= req_brake_pressed;
      end
   end

   // Range check and clamp
   assign cond_a = condition(t_a_ff, high_a_ff, low_a_ff, slop_ff);
   assign cond_b = condition(t_b_ff, high_b_ff, low_b_ff, slop_ff);

   always_ff @(posedge clock) begin
      if (cmd.cond) begin
         ok_ff     <= cond_a.ok & cond_b.ok;
         zero_a_ff <= cond_a.zero;
         zero_b_ff <= cond_b.zero;
      end
   end

   // Window memory, both channels side by side; entry at ptr is valid once wrapped
   dpsp_ram #(
      .WIDTH (2*VAL_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (ptr_ff),
      .wr_data ({v_a_ff, v_b_ff}),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign old_a = wrapped_ff ? rd_data[2*VAL_W-1:VAL_W] : '0;
   assign old_b = wrapped_ff ? rd_data[VAL_W-1:0] : '0;

   // Scaled value and updated running sums
   assign v_a_sel   = zero_a_ff ? '0 : q_a;
   assign v_b_sel   = zero_b_ff ? '0 : q_b;
   assign sum_a_new = sum_a_ff - SUM_W'(old_a) + SUM_W'(v_a_sel);
   assign sum_b_new = sum_b_ff - SUM_W'(old_b) + SUM_W'(v_b_sel);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         v_a_ff       <= v_a_sel;
         v_b_ff       <= v_b_sel;
         sum_a_new_ff <= sum_a_new;
         sum_b_new_ff <= sum_b_new;
      end
   end

   // Scaling divider operands
   assign dvd_a = cond_a.dividend;
   assign dvd_b = cond_b.dividend;
   assign dsr_a = {1'b0, high_a_ff - low_a_ff};
   assign dsr_b = {1'b0, high_b_ff - low_b_ff};

   dpsp_div u_div_a (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_a),
      .divisor  (dsr_a),
      .quotient (q_a)
   );

   dpsp_div u_div_b (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_b),
      .divisor  (dsr_b),
      .quotient (q_b)
   );

   // Window averages from the registered sums
   assign prod_a = PRD_W'(sum_a_new_ff) * PRD_W'(RCP_M);
   assign prod_b = PRD_W'(sum_b_new_ff) * PRD_W'(RCP_M);
   assign avg_a  = prod_a[RCP_K +: VAL_W];
   assign avg_b  = prod_b[RCP_K +: VAL_W];

   // Cross-check, deadzone and brake lockout on the averages
   assign diff     = (avg_a > avg_b) ? (avg_a - avg_b) : (avg_b - avg_a);
   assign disagree = ok_ff & (diff >= DISAGREE_LIMIT);
   assign dz_hi    = 8'd255 - {1'b0, dead_band_ff};
   assign dz_a     = deadzone(avg_a, dead_band_ff, dz_hi);
   assign dz_b     = deadzone(avg_b, dead_band_ff, dz_hi);
   assign lk_new   = brake_ff |
                     (lockout_ff & ~((dz_a < LOCKOUT_RELEASE) | (dz_b < LOCKOUT_RELEASE)));
   assign commit   = cmd.finish & ok_ff;
   assign pass     = ok_ff & ~disagree & ~lk_new;

   // Block state update
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         ptr_ff      <= '0;
         wrapped_ff  <= 1'b0;
         disagree_ff <= 1'b0;
         dis_cnt_ff  <= '0;
         lockout_ff  <= 1'b0;
      end else if (commit) begin
         sum_a_ff <= sum_a_new_ff;
         sum_b_ff <= sum_b_new_ff;
         if (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) begin
            ptr_ff     <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (disagree) begin
            disagree_ff <= 1'b1;
            dis_cnt_ff  <= dis_cnt_ff + 8'd1;
         end else begin
            lockout_ff <= lk_new;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_pedal_a_ff <= pass ? dz_a : '0;
         rsp_pedal_b_ff <= pass ? dz_b : '0;
         rsp_panic_ff   <= ~ok_ff | disagree;
         rsp_seen_ff    <= disagree_ff | disagree;
         rsp_total_ff   <= dis_cnt_ff + {7'd0, disagree};
         rsp_lockout_ff <= (ok_ff & ~disagree) ? lk_new : lockout_ff;
         rsp_brake_ff   <= brake_ff;
      end
   end

   assign status             = '{range_ok: cond_a.ok & cond_b.ok,
                                 out_free: ~rsp_valid_ff | rsp_ready};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pedal_a        = rsp_pedal_a_ff;
   assign rsp_pedal_b        = rsp_pedal_b_ff;
   assign rsp_panic          = rsp_panic_ff;
   assign rsp_disagree_seen  = rsp_seen_ff;
   assign rsp_disagree_total = rsp_total_ff;
   assign rsp_brake_lockout  = rsp_lockout_ff;
   assign rsp_brake_active   = rsp_brake_ff;

endmodule

// ----- hw/rtl/dual_pedal_sensor_plausibility.sv -----
// Channel   Handshake              Payload
// req       req_valid/req_ready    sensor_a[10], sensor_b[10], brake_pressed
// rsp       rsp_valid/rsp_ready    pedal_a, pedal_b, panic, disagree_seen,
//                                  disagree_total, brake_lockout, brake_active
// csr       csr_valid/csr_ready    csr_index[3], csr_data[8] (always ready)
//
// An item in range passes through transfer, check, 8 scaling divider steps,
// sum update and result load. Both channels share these steps in two divider
// lanes run side by side. An out-of-range item goes from the check straight
// to the result load. One item is in flight at a time.
// A stalled result holds the block in its last step; the next item is taken
// as soon as the result register is loaded. No clearing pass after reset.
module dual_pedal_sensor_plausibility import dpsp_pkg::*; #(
   parameter int WINDOW_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RAW_W-1:0]     req_sensor_a,
   input  logic [RAW_W-1:0]     req_sensor_b,
   input  logic                 req_brake_pressed,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_pedal_a,
   output logic [VAL_W-1:0]     rsp_pedal_b,
   output logic                 rsp_panic,
   output logic                 rsp_disagree_seen,
   output logic [VAL_W-1:0]     rsp_disagree_total,
   output logic                 rsp_brake_lockout,
   output logic                 rsp_brake_active,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data
);

   cmd_type    cmd;
   status_type status;

   dpsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpsp_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sensor_a       (req_sensor_a),
      .req_sensor_b       (req_sensor_b),
      .req_brake_pressed  (req_brake_pressed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pedal_a        (rsp_pedal_a),
      .rsp_pedal_b        (rsp_pedal_b),
      .rsp_panic          (rsp_panic),
      .rsp_disagree_seen  (rsp_disagree_seen),
      .rsp_disagree_total (rsp_disagree_total),
      .rsp_brake_lockout  (rsp_brake_lockout),
      .rsp_brake_active   (rsp_brake_active)
   );

endmodule

// ----- hw/rtl/dpsp_checker.sv -----
module dpsp_checker import dpsp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VAL_W-1:0]     rsp_pedal_a,
   input logic [VAL_W-1:0]     rsp_pedal_b,
   input logic                 rsp_panic,
   input logic                 rsp_brake_lockout,
   input logic                 rsp_brake_active
);

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item in flight: no transfer in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after a transfer");

   // A fault blanks both pedal values
   a_panic_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_panic) |-> (rsp_pedal_a == 8'd0 && rsp_pedal_b == 8'd0))
      else $error("pedal output during panic");

   // Brake or lockout blanks both pedal values
   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_brake_active || rsp_brake_lockout))
         |-> (rsp_pedal_a == 8'd0 && rsp_pedal_b == 8'd0))
      else $error("pedal output while braking or locked out");

endmodule

bind dual_pedal_sensor_plausibility dpsp_checker u_dpsp_checker (.*);
